// ===== sv/rrts_pkg.sv =====
// Package for the round-robin task scheduler core: event codes, task phases,
// beat structs and sequencer states. No dependencies.
package rrts_pkg;

  localparam int unsigned NumTasks = 16;
  localparam int unsigned TidW     = 4;
  localparam int unsigned CntW     = 5;
  localparam int unsigned DivSteps = 17;

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_START = 3'd1,
    KIND_YIELD = 3'd2,
    KIND_SLEEP = 3'd3,
    KIND_BLOCK = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_ABSENT = 2'd0,
    PH_READY  = 2'd1,
    PH_SLEEP  = 2'd2,
    PH_BLOCK  = 2'd3
  } phase_e;

  typedef enum logic [0:0] {
    REG_SLICE_LENGTH = 1'd0,
    REG_TICK_MS      = 1'd1
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_SLP_APPLY,
    S_WALK,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  task_id;
    logic [15:0] sleep_ms;
  } event_t;

  typedef struct packed {
    logic [3:0] current_task;
    logic       idle_running;
    logic       switched;
    logic [1:0] status;
    logic [4:0] ready_count;
  } result_t;

endpackage

// ===== sv/round_robin_task_scheduler_core.sv =====
// Round-robin task scheduler core: ready queue, sleep list, per-task slice
// and sleep counters under one sequencer. Depends on rrts_pkg.
//
// One event is taken at an edge where start is high and busy is low; its
// result appears on result_o for one cycle with result_valid_o, which cannot
// be stalled. The ready queue is a ring with a head pointer, so rotate, pop
// and push need no shifting. busy stays high while the sequencer decodes
// the event, walks every sleeper on a tick and, for a nonzero sleep, runs
// 17 restoring divide steps and appends the task to the sleep list. The
// result beat comes in the first cycle with busy low, so a new event is
// accepted only once the previous one is through.
module round_robin_task_scheduler_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  rrts_pkg::event_t      event_i,
  output logic                  result_valid_o,
  output rrts_pkg::result_t     result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [0:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i
);

  rrts_pkg::state_e state_q, state_d;

  logic [7:0]                  slice_len_q, tick_ms_q;
  logic [rrts_pkg::TidW-1:0]   rq_q [rrts_pkg::NumTasks];
  logic [rrts_pkg::TidW-1:0]   so_q [rrts_pkg::NumTasks];
  logic [15:0]                 sleep_left_q [rrts_pkg::NumTasks];
  logic [7:0]                  slice_left_q [rrts_pkg::NumTasks];
  rrts_pkg::phase_e            phase_q [rrts_pkg::NumTasks];
  logic [rrts_pkg::TidW-1:0]   rhead_q;
  logic [rrts_pkg::CntW-1:0]   rlen_q, slen_q;
  logic [rrts_pkg::TidW-1:0]   run_q;
  logic                        idle_q;

  rrts_pkg::event_t            ev_q;
  rrts_pkg::status_e           status_q;
  logic [rrts_pkg::CntW-1:0]   rd_idx_q, wr_idx_q;  // sleep list walk
  logic [7:0]                  rem_q;
  logic [16:0]                 num_q;               // dividend, then quotient
  logic [4:0]                  dcnt_q;
  rrts_pkg::result_t           result_q;
  logic                        result_valid_q;

  logic [rrts_pkg::TidW-1:0]   head_w, tail_w, tid_w, walk_t_w, rq_wd_w;
  logic [rrts_pkg::TidW-1:0]   so_wa_w, so_wd_w, fin_task_w;
  logic [7:0]                  div_w;
  logic [8:0]                  div_sh_w, div_sub_w;
  logic [16:0]                 div_num_w;
  logic                        div_ge_w, has_run_w, multi_w, push_ok_w, cur_exp_w;
  logic                        start_ok_w, walk_exp_w, last_walk_w, fin_idle_w;
  logic                        rotate_w, pop_w, push_w, start_go_w, wake_w;
  logic                        rq_we_w, so_we_w;
  rrts_pkg::status_e           dec_status_w;
  rrts_pkg::result_t           fin_result_w;

  assign busy           = (state_q != rrts_pkg::S_IDLE);
  assign cfg_ready_o    = (state_q == rrts_pkg::S_IDLE);
  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_len_q <= 8'd10;
      tick_ms_q   <= 8'd10;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == rrts_pkg::REG_SLICE_LENGTH) slice_len_q <= cfg_data_i;
      else tick_ms_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= rrts_pkg::S_IDLE;
    else state_q <= state_d;
  end

  assign head_w      = rq_q[rhead_q];
  assign tail_w      = rhead_q + rlen_q[rrts_pkg::TidW-1:0];
  assign tid_w       = ev_q.task_id;
  assign walk_t_w    = so_q[rd_idx_q[rrts_pkg::TidW-1:0]];
  assign has_run_w   = !idle_q && (rlen_q != 5'd0);
  assign multi_w     = (rlen_q > 5'd1);
  assign push_ok_w   = (rlen_q < 5'(rrts_pkg::NumTasks));
  assign cur_exp_w   = (slice_left_q[head_w] <= 8'd1);
  assign start_ok_w  = (phase_q[tid_w] == rrts_pkg::PH_ABSENT) ||
                       (phase_q[tid_w] == rrts_pkg::PH_BLOCK);
  assign walk_exp_w  = (sleep_left_q[walk_t_w] <= 16'd1);
  assign last_walk_w = (rd_idx_q + 5'd1 == slen_q);
  assign fin_idle_w  = (rlen_q == 5'd0);
  assign fin_task_w  = fin_idle_w ? run_q : head_w;

  // Restoring divide step for rounding a sleep up to ticks
  assign div_w     = (tick_ms_q == 8'd0) ? 8'd1 : tick_ms_q;
  assign div_sh_w  = {rem_q, num_q[16]};
  assign div_ge_w  = (div_sh_w >= {1'b0, div_w});
  assign div_sub_w = div_sh_w - {1'b0, div_w};
  assign div_num_w = {1'b0, ev_q.sleep_ms} + {9'd0, div_w} - 17'd1;

  assign start_go_w = (state_q == rrts_pkg::S_DECODE) &&
                      (ev_q.kind == rrts_pkg::KIND_START) && start_ok_w;
  assign wake_w     = (state_q == rrts_pkg::S_WALK) && walk_exp_w;
  assign push_w     = (start_go_w || wake_w) && push_ok_w;
  assign pop_w      = ((state_q == rrts_pkg::S_DECODE) &&
                       (ev_q.kind == rrts_pkg::KIND_BLOCK) && has_run_w) ||
                      (state_q == rrts_pkg::S_SLP_APPLY);
  assign rotate_w   = (state_q == rrts_pkg::S_DECODE) && multi_w &&
                      (((ev_q.kind == rrts_pkg::KIND_TICK) && has_run_w && cur_exp_w) ||
                       (ev_q.kind == rrts_pkg::KIND_YIELD) ||
                       ((ev_q.kind == rrts_pkg::KIND_SLEEP) && has_run_w &&
                        (ev_q.sleep_ms == 16'd0)));

  assign rq_we_w = rotate_w || push_w;
  assign rq_wd_w = rotate_w ? head_w : (wake_w ? walk_t_w : tid_w);

  // Append a new sleeper, and keep surviving sleepers in order by compacting the list in place
  assign so_we_w = ((state_q == rrts_pkg::S_SLP_APPLY) &&
                    (slen_q < 5'(rrts_pkg::NumTasks))) ||
                   ((state_q == rrts_pkg::S_WALK) && !walk_exp_w);
  assign so_wa_w = (state_q == rrts_pkg::S_WALK) ? wr_idx_q[rrts_pkg::TidW-1:0]
                                                 : slen_q[rrts_pkg::TidW-1:0];
  assign so_wd_w = (state_q == rrts_pkg::S_WALK) ? walk_t_w : head_w;

  always_comb begin
    dec_status_w = rrts_pkg::ST_OK;
    case (ev_q.kind)
      rrts_pkg::KIND_TICK:  dec_status_w = rrts_pkg::ST_OK;
      rrts_pkg::KIND_START: if (!start_ok_w) dec_status_w = rrts_pkg::ST_INVALID;
      rrts_pkg::KIND_YIELD: if (rlen_q == 5'd0) dec_status_w = rrts_pkg::ST_REFUSED;
      rrts_pkg::KIND_SLEEP,
      rrts_pkg::KIND_BLOCK: if (!has_run_w) dec_status_w = rrts_pkg::ST_INVALID;
      default:              dec_status_w = rrts_pkg::ST_INVALID;
    endcase
  end

  always_comb begin
    fin_result_w.current_task = fin_idle_w ? 4'd0 : fin_task_w;
    fin_result_w.idle_running = fin_idle_w;
    fin_result_w.switched     = (idle_q != fin_idle_w) ||
                                (!fin_idle_w && (run_q != fin_task_w));
    fin_result_w.status       = status_q;
    fin_result_w.ready_count  = rlen_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rrts_pkg::S_IDLE:      if (start) state_d = rrts_pkg::S_DECODE;
      rrts_pkg::S_DECODE: begin
        state_d = rrts_pkg::S_FINISH;
        if ((ev_q.kind == rrts_pkg::KIND_TICK) && (slen_q != 5'd0))
          state_d = rrts_pkg::S_WALK;
        else if ((ev_q.kind == rrts_pkg::KIND_SLEEP) && has_run_w &&
                 (ev_q.sleep_ms != 16'd0))
          state_d = rrts_pkg::S_DIV;
      end
      rrts_pkg::S_DIV:       if (dcnt_q == 5'd1) state_d = rrts_pkg::S_SLP_APPLY;
      rrts_pkg::S_SLP_APPLY: state_d = rrts_pkg::S_FINISH;
      rrts_pkg::S_WALK:      if (last_walk_w) state_d = rrts_pkg::S_FINISH;
      rrts_pkg::S_FINISH:    state_d = rrts_pkg::S_IDLE;
      default:               state_d = rrts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rq_we_w) rq_q[tail_w] <= rq_wd_w;
    if (so_we_w) so_q[so_wa_w] <= so_wd_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rhead_q        <= '0;
      rlen_q         <= '0;
      slen_q         <= '0;
      run_q          <= '0;
      idle_q         <= 1'b1;
      ev_q           <= '0;
      status_q       <= rrts_pkg::ST_OK;
      rd_idx_q       <= '0;
      wr_idx_q       <= '0;
      rem_q          <= '0;
      num_q          <= '0;
      dcnt_q         <= '0;
      result_q       <= '0;
      result_valid_q <= 1'b0;
      for (int i = 0; i < rrts_pkg::NumTasks; i++) begin
        sleep_left_q[i] <= '0;
        slice_left_q[i] <= '0;
        phase_q[i]      <= rrts_pkg::PH_ABSENT;
      end
    end else begin
      result_valid_q <= (state_q == rrts_pkg::S_FINISH);
      if (rotate_w || pop_w) rhead_q <= rhead_q + 4'd1;
      if (pop_w) rlen_q <= rlen_q - 5'd1;
      else if (push_w) rlen_q <= rlen_q + 5'd1;
      case (state_q)
        rrts_pkg::S_IDLE: if (start) ev_q <= event_i;
        rrts_pkg::S_DECODE: begin
          status_q <= dec_status_w;
          rd_idx_q <= '0;
          wr_idx_q <= '0;
          num_q    <= div_num_w;
          rem_q    <= '0;
          dcnt_q   <= 5'(rrts_pkg::DivSteps);
          case (ev_q.kind)
            rrts_pkg::KIND_TICK: begin
              if (has_run_w) begin
                if (cur_exp_w) slice_left_q[head_w] <= slice_len_q;
                else slice_left_q[head_w] <= slice_left_q[head_w] - 8'd1;
              end
            end
            rrts_pkg::KIND_START: begin
              if (phase_q[tid_w] == rrts_pkg::PH_ABSENT) begin
                slice_left_q[tid_w] <= slice_len_q;
                phase_q[tid_w]      <= rrts_pkg::PH_READY;
              end else if (phase_q[tid_w] == rrts_pkg::PH_BLOCK) begin
                phase_q[tid_w] <= rrts_pkg::PH_READY;
              end
            end
            rrts_pkg::KIND_BLOCK: if (has_run_w) phase_q[head_w] <= rrts_pkg::PH_BLOCK;
            default: ;
          endcase
        end
        rrts_pkg::S_DIV: begin
          rem_q  <= div_ge_w ? div_sub_w[7:0] : div_sh_w[7:0];
          num_q  <= {num_q[15:0], div_ge_w};
          dcnt_q <= dcnt_q - 5'd1;
        end
        rrts_pkg::S_SLP_APPLY: begin
          phase_q[head_w]      <= rrts_pkg::PH_SLEEP;
          sleep_left_q[head_w] <= num_q[15:0];
          if (slen_q < 5'(rrts_pkg::NumTasks)) slen_q <= slen_q + 5'd1;
        end
        rrts_pkg::S_WALK: begin
          rd_idx_q <= rd_idx_q + 5'd1;
          if (walk_exp_w) begin
            // drop the sleeper from the list and wake it
            sleep_left_q[walk_t_w] <= '0;
            phase_q[walk_t_w]      <= rrts_pkg::PH_READY;
            if (last_walk_w) slen_q <= wr_idx_q;
          end else begin
            sleep_left_q[walk_t_w] <= sleep_left_q[walk_t_w] - 16'd1;
            wr_idx_q               <= wr_idx_q + 5'd1;
            if (last_walk_w) slen_q <= wr_idx_q + 5'd1;
          end
        end
        rrts_pkg::S_FINISH: begin
          idle_q   <= fin_idle_w;
          run_q    <= fin_task_w;
          result_q <= fin_result_w;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for round_robin_task_scheduler_core: directed and
// random event streams checked against an in-bench scheduler predictor.
// Depends on rrts_pkg and the core only.
module tb_top;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 100;
  localparam logic [2:0] KindBadLo = 3'd5;
  localparam logic [2:0] KindBadHi = 3'd7;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  rrts_pkg::event_t  event_i = '0;
  logic              result_valid_o;
  rrts_pkg::result_t result_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [0:0]        cfg_index_i = rrts_pkg::REG_SLICE_LENGTH;
  logic [7:0]        cfg_data_i = '0;

  round_robin_task_scheduler_core u_top (
    .clk_i, .rst_ni, .start, .busy, .event_i, .result_valid_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scheduler state as the predictor sees it
  logic [7:0]        slice_len_q, tick_ms_q;
  logic [3:0]        run_queue [rrts_pkg::NumTasks];
  int unsigned       run_len;
  logic [3:0]        nap_order [rrts_pkg::NumTasks];
  int unsigned       nap_len;
  logic [15:0]       nap_left [rrts_pkg::NumTasks];
  logic [7:0]        slice_left [rrts_pkg::NumTasks];
  rrts_pkg::phase_e  phase [rrts_pkg::NumTasks];
  logic [3:0]        cur_task;
  logic              idle_q;

  rrts_pkg::result_t pending_results [$];
  int unsigned errors, events_sent, results_seen, switches_seen, cycles;

  function automatic void sched_reset();
    slice_len_q = 8'd10;
    tick_ms_q = 8'd10;
    run_len = 0;
    nap_len = 0;
    for (int i = 0; i < rrts_pkg::NumTasks; i++) begin
      run_queue[i] = '0;
      nap_order[i] = '0;
      nap_left[i] = '0;
      slice_left[i] = '0;
      phase[i] = rrts_pkg::PH_ABSENT;
    end
    cur_task = '0;
    idle_q = 1'b1;
  endfunction

  function automatic void queue_append(logic [3:0] t);
    if (run_len < rrts_pkg::NumTasks) begin
      run_queue[run_len] = t;
      run_len++;
    end
  endfunction

  function automatic logic [3:0] queue_take();
    logic [3:0] t;
    t = run_queue[0];
    if (run_len > 0) begin
      for (int i = 0; i + 1 < run_len; i++) run_queue[i] = run_queue[i+1];
      run_len--;
    end
    return t;
  endfunction

  function automatic void queue_rotate();
    if (run_len > 1) queue_append(queue_take());
  endfunction

  function automatic void wake_sleepers();
    int unsigned i;
    logic [3:0] t;
    i = 0;
    while (i < nap_len) begin
      t = nap_order[i];
      if (nap_left[t] <= 1) begin
        nap_left[t] = '0;
        for (int j = i; j + 1 < nap_len; j++) nap_order[j] = nap_order[j+1];
        nap_len--;
        phase[t] = rrts_pkg::PH_READY;
        queue_append(t);
      end else begin
        nap_left[t]--;
        i++;
      end
    end
  endfunction

  function automatic rrts_pkg::result_t schedule_event(rrts_pkg::event_t ev);
    rrts_pkg::result_t r;
    logic [1:0] st;
    logic was_idle;
    logic [3:0] was_task, t;
    int unsigned div, ticks;
    st = rrts_pkg::ST_OK;
    was_idle = idle_q;
    was_task = cur_task;
    case (ev.kind)
      rrts_pkg::KIND_TICK: begin
        if (!idle_q && run_len > 0) begin
          t = run_queue[0];
          if (slice_left[t] <= 1) begin
            slice_left[t] = slice_len_q;
            queue_rotate();
          end else begin
            slice_left[t]--;
          end
        end
        wake_sleepers();
      end
      rrts_pkg::KIND_START: begin
        t = ev.task_id;
        if (phase[t] == rrts_pkg::PH_ABSENT) begin
          slice_left[t] = slice_len_q;
          phase[t] = rrts_pkg::PH_READY;
          queue_append(t);
        end else if (phase[t] == rrts_pkg::PH_BLOCK) begin
          phase[t] = rrts_pkg::PH_READY;
          queue_append(t);
        end else begin
          st = rrts_pkg::ST_INVALID;
        end
      end
      rrts_pkg::KIND_YIELD: begin
        if (run_len == 0) st = rrts_pkg::ST_REFUSED;
        else queue_rotate();
      end
      rrts_pkg::KIND_SLEEP: begin
        if (idle_q || run_len == 0) begin
          st = rrts_pkg::ST_INVALID;
        end else begin
          div = (tick_ms_q == 0) ? 1 : tick_ms_q;
          ticks = (ev.sleep_ms + div - 1) / div;
          if (ticks == 0) begin
            queue_rotate();
          end else begin
            t = queue_take();
            phase[t] = rrts_pkg::PH_SLEEP;
            nap_left[t] = ticks[15:0];
            if (nap_len < rrts_pkg::NumTasks) begin
              nap_order[nap_len] = t;
              nap_len++;
            end
          end
        end
      end
      rrts_pkg::KIND_BLOCK: begin
        if (idle_q || run_len == 0) begin
          st = rrts_pkg::ST_INVALID;
        end else begin
          t = queue_take();
          phase[t] = rrts_pkg::PH_BLOCK;
        end
      end
      default: st = rrts_pkg::ST_INVALID;
    endcase
    if (run_len > 0) begin
      idle_q = 1'b0;
      cur_task = run_queue[0];
    end else begin
      idle_q = 1'b1;
    end
    r.current_task = idle_q ? 4'd0 : cur_task;
    r.idle_running = idle_q;
    r.switched = (was_idle != idle_q) || (!idle_q && was_task != cur_task);
    r.status = st;
    r.ready_count = run_len[4:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch on %s at cycle %0d: got %0d, want %0d", what, cycles, got, want);
    errors++;
  endtask

  // Check each result beat against the oldest prediction
  always @(posedge clk_i) begin
    rrts_pkg::result_t want;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (result_o.switched) switches_seen++;
        if (result_o.current_task !== want.current_task)
          report_mismatch("current_task", result_o.current_task, want.current_task);
        if (result_o.idle_running !== want.idle_running)
          report_mismatch("idle_running", result_o.idle_running, want.idle_running);
        if (result_o.switched !== want.switched)
          report_mismatch("switched", result_o.switched, want.switched);
        if (result_o.status !== want.status)
          report_mismatch("status", result_o.status, want.status);
        if (result_o.ready_count !== want.ready_count)
          report_mismatch("ready_count", result_o.ready_count, want.ready_count);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[round_robin_task_scheduler_core] ERROR");
      $finish;
    end
  end

  // Start stays high after the beat; the caller drops it in a gap
  task automatic send_event(logic [2:0] kind, logic [3:0] tid, logic [15:0] ms);
    rrts_pkg::event_t ev;
    ev.kind = kind;
    ev.task_id = tid;
    ev.sleep_ms = ms;
    start <= 1'b1;
    event_i <= ev;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(schedule_event(ev));
    events_sent++;
  endtask

  task automatic pause(int unsigned n);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Valid stays high between writes; the caller drops it after the last one
  task automatic write_reg(rrts_pkg::reg_e idx, logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == rrts_pkg::REG_SLICE_LENGTH) slice_len_q = value;
    else tick_ms_q = value;
  endtask

  task automatic configure(logic [7:0] slice, logic [7:0] tick);
    drain();
    write_reg(rrts_pkg::REG_SLICE_LENGTH, slice);
    write_reg(rrts_pkg::REG_TICK_MS, tick);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_idle_requests();
    send_event(rrts_pkg::KIND_YIELD, 4'd0, 16'd0);
    send_event(rrts_pkg::KIND_SLEEP, 4'd0, 16'd5);
    send_event(rrts_pkg::KIND_BLOCK, 4'd0, 16'd0);
    send_event(rrts_pkg::KIND_TICK, 4'd0, 16'd0);
    for (logic [2:0] k = KindBadLo; k <= KindBadHi && k >= KindBadLo; k++)
      send_event(k, 4'hf, 16'hffff);
  endtask

  task automatic test_task_lifecycle();
    send_event(rrts_pkg::KIND_START, 4'd0, 16'd0);
    send_event(rrts_pkg::KIND_YIELD, 4'd0, 16'd0);
    send_event(rrts_pkg::KIND_START, 4'd0, 16'd0);
    send_event(rrts_pkg::KIND_START, 4'd15, 16'd0);
    send_event(rrts_pkg::KIND_YIELD, 4'd0, 16'd0);
    send_event(rrts_pkg::KIND_SLEEP, 4'd0, 16'd0);
    send_event(rrts_pkg::KIND_SLEEP, 4'd0, 16'd25);
    send_event(rrts_pkg::KIND_START, 4'd15, 16'd0);
    send_event(rrts_pkg::KIND_TICK, 4'd0, 16'd0);
    send_event(rrts_pkg::KIND_TICK, 4'd0, 16'd0);
    send_event(rrts_pkg::KIND_TICK, 4'd0, 16'd0);
    send_event(rrts_pkg::KIND_BLOCK, 4'd0, 16'd0);
    send_event(rrts_pkg::KIND_START, 4'd15, 16'd0);
    send_event(rrts_pkg::KIND_SLEEP, 4'd0, 16'hffff);
    send_event(rrts_pkg::KIND_BLOCK, 4'd0, 16'd0);
    send_event(rrts_pkg::KIND_TICK, 4'd0, 16'd0);
    pause(1);
  endtask

  task automatic test_config_extremes();
    configure(8'd0, 8'd0);
    send_event(rrts_pkg::KIND_START, 4'd3, 16'd0);
    send_event(rrts_pkg::KIND_START, 4'd4, 16'd0);
    send_event(rrts_pkg::KIND_TICK, 4'd0, 16'd0);
    send_event(rrts_pkg::KIND_SLEEP, 4'd0, 16'd1);
    send_event(rrts_pkg::KIND_TICK, 4'd0, 16'd0);
    configure(8'd255, 8'd255);
    send_event(rrts_pkg::KIND_SLEEP, 4'd0, 16'd256);
    send_event(rrts_pkg::KIND_TICK, 4'd0, 16'd0);
    pause(1);
  endtask

  task automatic test_random(logic [7:0] slice, logic [7:0] tick, int unsigned n);
    int unsigned burst, sel, tickdiv;
    logic [2:0] k;
    logic [15:0] ms;
    configure(slice, tick);
    tickdiv = (tick == 0) ? 1 : tick;
    burst = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) pause($urandom_range(0, 40));
      end
      burst--;
      sel = $urandom_range(0, 99);
      if (sel < 40) k = rrts_pkg::KIND_TICK;
      else if (sel < 62) k = rrts_pkg::KIND_START;
      else if (sel < 72) k = rrts_pkg::KIND_YIELD;
      else if (sel < 86) k = rrts_pkg::KIND_SLEEP;
      else if (sel < 96) k = rrts_pkg::KIND_BLOCK;
      else k = 3'($urandom_range(KindBadLo, KindBadHi));
      // mostly short naps so sleepers come back; now and then any value
      if ($urandom_range(0, 15) == 0) ms = 16'($urandom);
      else ms = 16'($urandom_range(0, 6 * tickdiv));
      send_event(k, 4'($urandom_range(0, rrts_pkg::NumTasks - 1)), ms);
    end
    pause(1);
  endtask

  initial begin
    sched_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_requests();
    test_task_lifecycle();
    test_config_extremes();
    test_random(8'd10, 8'd10, 400);
    test_random(8'd1, 8'd1, 400);
    test_random(8'd255, 8'd255, 400);
    test_random(8'd0, 8'd0, 400);
    test_random(8'($urandom_range(2, 20)), 8'($urandom_range(1, 50)), 400);
    drain();
    $display("sent %0d events, checked %0d results (%0d task switches) over %0d cycles",
             events_sent, results_seen, switches_seen, cycles);
    $display("covered idle requests, task lifecycle, register extremes and random mixes");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[round_robin_task_scheduler_core] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("[round_robin_task_scheduler_core] ERROR");
    end
    $finish;
  end

endmodule
